### rtl/core/pss_pkg.sv
package pss_pkg;

   // Register widths and reset values
   localparam int THRESHOLD_BITS = 12;
   localparam int SETTLE_BITS    = 16;
   localparam int TIME_BITS      = 32;
   localparam int RATE_BITS      = 16;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 3;

   localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 12'd10;
   localparam logic [SETTLE_BITS-1:0]    SETTLE_RESET    = 16'd50;

   // Register index, taken from paddr[2]
   localparam logic CSR_IDX_THRESHOLD = 1'b0;
   localparam logic CSR_IDX_SETTLE    = 1'b1;

   // Q14 full scale
   localparam int Q14_ONE = 16384;

   // Per-stage pipeline control
   typedef struct packed {
      logic adv;   // pipeline moves this cycle
      logic load;  // a valid request moves out of this stage
   } stage_ctl_type;

endpackage

### rtl/core/pss_req_if.sv
interface pss_req_if #(parameter int SAMPLE_BITS = 12);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   logic [31:0]            time_ms;

   modport source (output valid, sample, time_ms, input ready);
   modport sink   (input valid, sample, time_ms, output ready);
endinterface

### rtl/core/pss_rsp_if.sv
interface pss_rsp_if #(parameter int SAMPLE_BITS = 12);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] reported_value;
   logic                   changed;
   logic signed [15:0]     centered_rate;

   modport source (output valid, reported_value, changed, centered_rate, input ready);
   modport sink   (input valid, reported_value, changed, centered_rate, output ready);
endinterface

### rtl/core/pss_cdiv.sv
// Floor division by a constant through a reciprocal multiply.
// Exact for every numerator below 2^NUM_BITS.
module pss_cdiv #(
   parameter int NUM_BITS = 24,
   parameter int DIVISOR  = 10,
   parameter int QUO_BITS = 20
) (
   input  logic [NUM_BITS-1:0] num,
   output logic [QUO_BITS-1:0] quo
);

   localparam int          SHIFT    = NUM_BITS + $clog2(DIVISOR);
   localparam int          MUL_BITS = NUM_BITS + 2;
   localparam logic [63:0] MUL_FULL = ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1)
                                      / 64'(DIVISOR);
   localparam logic [MUL_BITS-1:0] MUL = MUL_FULL[MUL_BITS-1:0];

   logic [NUM_BITS+MUL_BITS-1:0] prod;

   assign prod = {{MUL_BITS{1'b0}}, num} * {{NUM_BITS{1'b0}}, MUL};
   assign quo  = prod[SHIFT +: QUO_BITS];

endmodule

### rtl/core/pss_track.sv
// Moving average, change test with settle timer, and reported value.
module pss_track
   import pss_pkg::*;
#(
   parameter int SAMPLE_BITS   = 12,
   parameter int AVG_FRAC_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  stage_ctl_type             ctl,
   input  logic [SAMPLE_BITS-1:0]    sample,
   input  logic [TIME_BITS-1:0]      time_ms,
   input  logic [THRESHOLD_BITS-1:0] threshold,
   input  logic [SETTLE_BITS-1:0]    settle,
   output logic [SAMPLE_BITS-1:0]    code_ff,
   output logic                      changed_ff
);

   localparam int AVG_BITS = SAMPLE_BITS + AVG_FRAC_BITS;
   localparam int SUM_BITS = AVG_BITS + 4;
   localparam int CMP_BITS = (SAMPLE_BITS > THRESHOLD_BITS ? SAMPLE_BITS : THRESHOLD_BITS)
                             + AVG_FRAC_BITS;
   localparam logic [SUM_BITS-1:0] AVG_ROUND = SUM_BITS'(5);
   localparam logic [AVG_BITS:0]   HALF_LSB  = (AVG_BITS+1)'(1) << (AVG_FRAC_BITS - 1);

   logic [AVG_BITS-1:0]    avg_ff, avg_in;
   logic [SAMPLE_BITS-1:0] reported_ff, reported_in;
   logic [TIME_BITS-1:0]   start_ff, start_in;
   logic [SAMPLE_BITS-1:0] code_in;
   logic                   changed_in;

   logic [SUM_BITS-1:0]    sum;
   logic [AVG_BITS-1:0]    rep_fx;
   logic [AVG_BITS-1:0]    avg_dist;
   logic [CMP_BITS-1:0]    dist_ext, thr_fx;
   logic [TIME_BITS-1:0]   elapsed;
   logic [AVG_BITS:0]      rnd;
   logic [SAMPLE_BITS:0]   rnd_code;
   logic [SAMPLE_BITS-1:0] new_code;
   logic                   far, persisted;

   // 9*avg + sample + rounding, then divide by ten
   assign sum = (SUM_BITS'(avg_ff) << 3) + SUM_BITS'(avg_ff)
                + (SUM_BITS'(sample) << AVG_FRAC_BITS) + AVG_ROUND;

   pss_cdiv #(
      .NUM_BITS (SUM_BITS),
      .DIVISOR  (10),
      .QUO_BITS (AVG_BITS)
   ) u_div10 (
      .num (sum),
      .quo (avg_in)
   );

   // Distance from the reported value, exact in fixed point
   assign rep_fx   = {reported_ff, {AVG_FRAC_BITS{1'b0}}};
   assign avg_dist = (avg_in >= rep_fx) ? (avg_in - rep_fx) : (rep_fx - avg_in);
   assign dist_ext = CMP_BITS'(avg_dist);
   assign thr_fx   = CMP_BITS'({threshold, {AVG_FRAC_BITS{1'b0}}});
   assign far      = (dist_ext >= thr_fx);

   // Settle timer, wraps modulo 2^32
   assign elapsed   = time_ms - start_ff;
   assign persisted = (elapsed > TIME_BITS'(settle));

   // Rounded average, saturated to the sample range
   assign rnd      = {1'b0, avg_in} + HALF_LSB;
   assign rnd_code = rnd[AVG_BITS:AVG_FRAC_BITS];
   assign new_code = rnd_code[SAMPLE_BITS] ? {SAMPLE_BITS{1'b1}}
                                           : rnd_code[SAMPLE_BITS-1:0];

   always_comb begin
      reported_in = reported_ff;
      start_in    = start_ff;
      changed_in  = 1'b0;
      if (far) begin
         if (persisted) begin
            reported_in = new_code;
            changed_in  = 1'b1;
         end
      end else begin
         start_in = time_ms;
      end
      code_in = reported_in;
   end

   // State
   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff      <= '0;
         reported_ff <= '0;
         start_ff    <= '0;
      end else if (ctl.load) begin
         avg_ff      <= avg_in;
         reported_ff <= reported_in;
         start_ff    <= start_in;
      end
   end

   // Stage register toward the rate mapping
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         code_ff    <= code_in;
         changed_ff <= changed_in;
      end
   end

endmodule

### rtl/core/pss_rate.sv
// Maps the reported code to a Q14 centered rate with a dead zone; holds it
// between acceptances.
module pss_rate
   import pss_pkg::*;
#(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  stage_ctl_type               ctl,
   input  logic [SAMPLE_BITS-1:0]      code,
   input  logic                        changed,
   output logic signed [RATE_BITS-1:0] rate_ff
);

   localparam int CODE_SPAN = 2 ** SAMPLE_BITS;
   localparam int POS_LO    = (CODE_SPAN * 40 + 50) / 100;
   localparam int POS_HI    = (CODE_SPAN * 95 + 50) / 100;
   localparam int NEG_HI    = (CODE_SPAN * 30 + 50) / 100;
   localparam int NEG_LO    = (CODE_SPAN * 5 + 50) / 100;
   localparam int POS_SPAN  = POS_HI - POS_LO;
   localparam int NEG_SPAN  = NEG_HI - NEG_LO;
   localparam int NUM_BITS  = SAMPLE_BITS + 15;
   localparam int MAG_BITS  = 15;

   localparam logic [SAMPLE_BITS-1:0] POS_LO_C = SAMPLE_BITS'(POS_LO);
   localparam logic [SAMPLE_BITS-1:0] POS_HI_C = SAMPLE_BITS'(POS_HI);
   localparam logic [SAMPLE_BITS-1:0] NEG_HI_C = SAMPLE_BITS'(NEG_HI);
   localparam logic [SAMPLE_BITS-1:0] NEG_LO_C = SAMPLE_BITS'(NEG_LO);
   localparam logic [MAG_BITS-1:0]    ONE_MAG  = MAG_BITS'(Q14_ONE);

   logic [SAMPLE_BITS-1:0]       pos_off, neg_off;
   logic [NUM_BITS-1:0]          pos_num, neg_num;
   logic [MAG_BITS-1:0]          pos_quo, neg_quo, pos_mag, neg_mag;
   logic signed [RATE_BITS-1:0]  rate_in;

   // Scaled offsets into each ramp, with half-divisor rounding
   assign pos_off = code - POS_LO_C;
   assign neg_off = NEG_HI_C - code;
   assign pos_num = (NUM_BITS'(pos_off) << 14) + NUM_BITS'(POS_SPAN / 2);
   assign neg_num = (NUM_BITS'(neg_off) << 14) + NUM_BITS'(NEG_SPAN / 2);

   pss_cdiv #(
      .NUM_BITS (NUM_BITS),
      .DIVISOR  (POS_SPAN),
      .QUO_BITS (MAG_BITS)
   ) u_pos_div (
      .num (pos_num),
      .quo (pos_quo)
   );

   pss_cdiv #(
      .NUM_BITS (NUM_BITS),
      .DIVISOR  (NEG_SPAN),
      .QUO_BITS (MAG_BITS)
   ) u_neg_div (
      .num (neg_num),
      .quo (neg_quo)
   );

   // Clamp each ramp at its ends
   always_comb begin
      if (code >= POS_HI_C) begin
         pos_mag = ONE_MAG;
      end else if (code > POS_LO_C) begin
         pos_mag = pos_quo;
      end else begin
         pos_mag = '0;
      end
      if (code <= NEG_LO_C) begin
         neg_mag = ONE_MAG;
      end else if (code < NEG_HI_C) begin
         neg_mag = neg_quo;
      end else begin
         neg_mag = '0;
      end
      rate_in = $signed({1'b0, pos_mag}) - $signed({1'b0, neg_mag});
   end

   // Held rate, refreshed only when a new value is accepted
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= '0;
      end else if (ctl.load && changed) begin
         rate_ff <= rate_in;
      end
   end

endmodule

### rtl/core/pot_sample_smoother_with_settle.sv
// Knob sample smoother with settle time and centered-rate output.
// An accepted request passes the input register, the average/settle stage and the rate-mapping
// stage with its output register before the response is valid.
// Reset (synchronous, active high): average, reported value, settle start and held rate
// clear to zero; change_threshold returns to 10 and settle_ms to 50; pipeline emptied.
module pot_sample_smoother_with_settle
   import pss_pkg::*;
#(
   parameter int SAMPLE_BITS   = 12,
   parameter int AVG_FRAC_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   pss_req_if.sink                  req_chan,
   pss_rsp_if.source                rsp_chan,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   logic [THRESHOLD_BITS-1:0] threshold_ff;
   logic [SETTLE_BITS-1:0]    settle_ff;
   logic                      csr_write;

   logic                   in_vld_ff, mid_vld_ff, out_vld_ff;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [TIME_BITS-1:0]   time_ff;
   logic [SAMPLE_BITS-1:0] mid_code, out_code_ff;
   logic                   mid_changed, out_changed_ff;
   logic                   adv;
   stage_ctl_type          track_ctl, rate_ctl;

   // Configuration registers
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         settle_ff    <= SETTLE_RESET;
      end else if (csr_write) begin
         unique case (paddr[2])
            CSR_IDX_THRESHOLD: threshold_ff <= pwdata[THRESHOLD_BITS-1:0];
            CSR_IDX_SETTLE:    settle_ff    <= pwdata[SETTLE_BITS-1:0];
            default:           threshold_ff <= threshold_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         CSR_IDX_THRESHOLD: prdata = CSR_DATA_BITS'(threshold_ff);
         CSR_IDX_SETTLE:    prdata = CSR_DATA_BITS'(settle_ff);
         default:           prdata = '0;
      endcase
   end

   // Pipeline advance: the whole pipe moves unless the response is stalled
   assign adv            = !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign track_ctl      = '{adv: adv, load: adv && in_vld_ff};
   assign rate_ctl       = '{adv: adv, load: adv && mid_vld_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         mid_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         in_vld_ff  <= req_chan.valid;
         mid_vld_ff <= in_vld_ff;
         out_vld_ff <= mid_vld_ff;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (adv && req_chan.valid) begin
         sample_ff <= req_chan.sample;
         time_ff   <= req_chan.time_ms;
      end
   end

   pss_track #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .AVG_FRAC_BITS (AVG_FRAC_BITS)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .ctl        (track_ctl),
      .sample     (sample_ff),
      .time_ms    (time_ff),
      .threshold  (threshold_ff),
      .settle     (settle_ff),
      .code_ff    (mid_code),
      .changed_ff (mid_changed)
   );

   pss_rate #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_rate (
      .clock   (clock),
      .reset   (reset),
      .ctl     (rate_ctl),
      .code    (mid_code),
      .changed (mid_changed),
      .rate_ff (rsp_chan.centered_rate)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (rate_ctl.load) begin
         out_code_ff    <= mid_code;
         out_changed_ff <= mid_changed;
      end
   end

   assign rsp_chan.valid          = out_vld_ff;
   assign rsp_chan.reported_value = out_code_ff;
   assign rsp_chan.changed        = out_changed_ff;

endmodule

### bench/pot_sample_smoother_with_settle_test.sv
module pot_sample_smoother_with_settle_test;
   timeunit 1ns;
   timeprecision 1ps;

   import pss_pkg::*;

   localparam int SAMPLE_W   = 12;
   localparam int FRAC_W     = 8;
   localparam int AVG_W      = SAMPLE_W + FRAC_W;
   localparam int SAMPLE_TOP = (1 << SAMPLE_W) - 1;
   localparam int CODE_SPAN  = 1 << SAMPLE_W;
   // dead-zone rate map breakpoints, rounded to the nearest code
   localparam int POS_LO     = (CODE_SPAN * 40 + 50) / 100;
   localparam int POS_HI     = (CODE_SPAN * 95 + 50) / 100;
   localparam int NEG_HI     = (CODE_SPAN * 30 + 50) / 100;
   localparam int NEG_LO     = (CODE_SPAN * 5 + 50) / 100;
   localparam int IDLE_MAX   = 17;
   localparam int PHASE_REQS = 100;

   typedef struct {
      logic [SAMPLE_W-1:0]         value;
      logic                        changed;
      logic signed [RATE_BITS-1:0] rate;
   } knob_result_type;

   // Smoother model plus the queue of responses still owed by the block
   class knob_rate_scoreboard;
      logic [THRESHOLD_BITS-1:0]   threshold;
      logic [SETTLE_BITS-1:0]      settle_ms;
      logic [AVG_W-1:0]            average;
      logic [SAMPLE_W-1:0]         reported;
      logic [TIME_BITS-1:0]        settle_start;
      logic signed [RATE_BITS-1:0] rate_held;
      knob_result_type             owed_q[$];
      int                          mismatches;
      int                          responses;
      int                          value_changes;

      function new();
         threshold     = THRESHOLD_RESET;
         settle_ms     = SETTLE_RESET;
         average       = '0;
         reported      = '0;
         settle_start  = '0;
         rate_held     = '0;
         mismatches    = 0;
         responses     = 0;
         value_changes = 0;
      endfunction

      // Q14 rate: positive ramp above the dead zone, negative ramp below it
      function int rate_for_code(int code);
         int pos;
         int neg;
         int span;
         pos = 0;
         neg = 0;
         if (code >= POS_HI) begin
            pos = Q14_ONE;
         end else if (code > POS_LO) begin
            span = POS_HI - POS_LO;
            pos  = ((code - POS_LO) * Q14_ONE + span / 2) / span;
         end
         if (code <= NEG_LO) begin
            neg = -Q14_ONE;
         end else if (code < NEG_HI) begin
            span = NEG_HI - NEG_LO;
            neg  = -(((NEG_HI - code) * Q14_ONE + span / 2) / span);
         end
         return pos + neg;
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] smp, logic [TIME_BITS-1:0] now);
         longint unsigned      avg_next;
         longint unsigned      smp_fx;
         longint unsigned      rep_fx;
         longint unsigned      thr_fx;
         longint unsigned      avg_dist;
         longint unsigned      rounded;
         logic [TIME_BITS-1:0] elapsed;
         knob_result_type      res;
         res.changed = 1'b0;

         // average = (9*average + sample) / 10, rounded half up in fixed point
         avg_next = average;
         smp_fx   = smp;
         avg_next = (9 * avg_next + (smp_fx << FRAC_W) + 5) / 10;
         average  = AVG_W'(avg_next);

         rep_fx   = reported;
         rep_fx   = rep_fx << FRAC_W;
         thr_fx   = threshold;
         thr_fx   = thr_fx << FRAC_W;
         avg_dist = (avg_next >= rep_fx) ? avg_next - rep_fx : rep_fx - avg_next;

         if (avg_dist >= thr_fx) begin
            // difference must outlast settle_ms, time wraps at 32 bits
            elapsed = now - settle_start;
            if (elapsed > settle_ms) begin
               rounded = (avg_next + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
               if (rounded > SAMPLE_TOP) begin
                  rounded = SAMPLE_TOP;
               end
               reported    = SAMPLE_W'(rounded);
               rate_held   = RATE_BITS'(rate_for_code(int'(rounded)));
               res.changed = 1'b1;
            end
         end else begin
            settle_start = now;
         end

         res.value = reported;
         res.rate  = rate_held;
         owed_q.push_back(res);
      endfunction

      function void check_response(knob_result_type got);
         knob_result_type want;
         responses++;
         if (owed_q.size() == 0) begin
            $error("response with no request outstanding: reported_value %0d", got.value);
            mismatches++;
            return;
         end
         want = owed_q.pop_front();
         if (got.value !== want.value) begin
            $error("reported_value: expected %0d, got %0d", want.value, got.value);
            mismatches++;
         end
         if (got.changed !== want.changed) begin
            $error("changed: expected %0d, got %0d", want.changed, got.changed);
            mismatches++;
         end
         if (got.rate !== want.rate) begin
            $error("centered_rate: expected %0d, got %0d", want.rate, got.rate);
            mismatches++;
         end
         if (want.changed) begin
            value_changes++;
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   int req_idle_max = 0;
   int rsp_idle_max = 0;
   int requests_sent = 0;
   int settings_used = 1;

   knob_rate_scoreboard board = new();

   pss_req_if #(.SAMPLE_BITS(SAMPLE_W)) req_chan ();
   pss_rsp_if #(.SAMPLE_BITS(SAMPLE_W)) rsp_chan ();

   pot_sample_smoother_with_settle #(
      .SAMPLE_BITS  (SAMPLE_W),
      .AVG_FRAC_BITS(FRAC_W)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.sample  = '0;
      req_chan.time_ms = '0;
   end

   // response side: random stall before each response, none when the limit is 0
   initial begin : rsp_stall
      int stall;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = $urandom_range(0, rsp_idle_max);
         if (stall > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : rsp_monitor
      knob_result_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.value   = rsp_chan.reported_value;
         got.changed = rsp_chan.changed;
         got.rate    = rsp_chan.centered_rate;
         board.check_response(got);
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_request(input logic [SAMPLE_W-1:0] smp, input logic [TIME_BITS-1:0] now);
      int gap;
      gap = $urandom_range(0, req_idle_max);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid   = 1'b1;
      req_chan.sample  = smp;
      req_chan.time_ms = now;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      board.note_sample(smp, now);
      requests_sent++;
      @(negedge clock);
   endtask

   // setup cycle, then access cycle; model register follows at the write edge
   task automatic write_register(input logic idx, input logic [CSR_DATA_BITS-1:0] value);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (idx == CSR_IDX_THRESHOLD) begin
         board.threshold = value[THRESHOLD_BITS-1:0];
      end else begin
         board.settle_ms = value[SETTLE_BITS-1:0];
      end
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic wait_drained();
      while (board.owed_q.size() != 0) @(negedge clock);
   endtask

   // Mostly held knob positions with jitter and advancing time, some raw noise
   task automatic run_phase(input int thr, input int settle, input logic [TIME_BITS-1:0] start,
                            input int idle);
      int                   done;
      int                   kind;
      int                   level;
      int                   jitter;
      int                   len;
      int                   k;
      int                   smp;
      int                   step_max;
      bit                   paused;
      logic [TIME_BITS-1:0] now;

      // upper bits are random to show the register masks them
      write_register(CSR_IDX_THRESHOLD, ($urandom << THRESHOLD_BITS) | thr);
      write_register(CSR_IDX_SETTLE, ($urandom << SETTLE_BITS) | settle);
      settings_used++;
      req_idle_max = idle;
      rsp_idle_max = idle;
      now      = start;
      step_max = settle / 5 + 4;
      paused   = 1'b0;
      done     = 0;

      while (done < PHASE_REQS) begin
         // hold the sender once until the block has answered everything
         if (!paused && done >= PHASE_REQS / 2) begin
            req_chan.valid = 1'b0;
            wait_drained();
            paused = 1'b1;
         end
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            send_request(SAMPLE_W'($urandom), $urandom);
            done++;
         end else begin
            if (kind == 1) begin
               now = now + $urandom;
            end
            if ($urandom_range(0, 3) == 0) begin
               level = $urandom_range(0, 1) ? SAMPLE_TOP : 0;
            end else begin
               level = $urandom_range(0, SAMPLE_TOP);
            end
            jitter = $urandom_range(0, 6);
            len    = $urandom_range(4, 40);
            for (k = 0; k < len && done < PHASE_REQS; k++) begin
               smp = level + int'($urandom_range(0, 2 * jitter)) - jitter;
               if (smp < 0) begin
                  smp = 0;
               end else if (smp > SAMPLE_TOP) begin
                  smp = SAMPLE_TOP;
               end
               now = now + $urandom_range(0, step_max);
               send_request(SAMPLE_W'(smp), now);
               done++;
            end
         end
      end
      req_chan.valid = 1'b0;
      wait_drained();
      repeat (4) @(negedge clock);
   endtask

   initial begin : stimulus
      int k;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed, at reset register values: settle boundary, wraps, ramps
      send_request(12'd0, 32'd0);             // average stays at zero
      send_request(12'hFFF, 32'd10);          // large step, not yet settled
      send_request(12'hFFF, 32'd50);          // exactly settle_ms: still waiting
      send_request(12'hFFF, 32'd51);          // one past: accepted
      for (k = 0; k < 8; k++) begin
         send_request(12'hFFF, 32'd60 + 10 * k);
      end
      send_request(12'h555, 32'hFFFF_FFF0);
      send_request(12'hAAA, 32'hFFFF_FFFF);
      for (k = 0; k < 8; k++) begin
         send_request(12'd0, 32'd5 + 40 * k); // time wrapped past zero
      end
      req_chan.valid = 1'b0;
      wait_drained();
      repeat (4) @(negedge clock);

      // Random phases over register settings, extremes included
      run_phase(0, 0, $urandom, IDLE_MAX);
      run_phase(4095, 65535, 32'hFFFF_FF00, 0);
      run_phase(1, 1, $urandom, IDLE_MAX);
      run_phase(10, 50, $urandom, 0);
      run_phase($urandom_range(0, 300), $urandom_range(0, 400), $urandom, IDLE_MAX);
      run_phase(3, 65535, $urandom, IDLE_MAX);
      run_phase($urandom_range(0, 4095), $urandom_range(0, 65535), $urandom, IDLE_MAX);
      run_phase(20, 0, 32'hFFFF_FFF0, 0);

      wait_drained();
      repeat (8) @(posedge clock);

      $display("Covered %0d requests under %0d register settings: %0d responses checked,",
               requests_sent, settings_used, board.responses);
      $display("%0d of them accepting a new knob value.", board.value_changes);
      if (board.mismatches == 0 && board.owed_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("Timed out with %0d responses outstanding", board.owed_q.size());
      $display("Some tests failed");
      $finish;
   end

endmodule

### sim.f
rtl/core/pss_pkg.sv
rtl/core/pss_req_if.sv
rtl/core/pss_rsp_if.sv
rtl/core/pss_cdiv.sv
rtl/core/pss_track.sv
rtl/core/pss_rate.sv
rtl/core/pot_sample_smoother_with_settle.sv
bench/pot_sample_smoother_with_settle_test.sv
